@@ rtl/core/lpfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfc_pkg
// Shared constants and types of the length-prefixed frame checker.
// ----------------------------------------------------------------------------
package lpfc_pkg;

	localparam int MAX_TAG_BYTES = 8;
	localparam int LENGTH_WIDTH  = 27;

	localparam int CFG_LEN_W  = 27;
	localparam int BODY_W     = 27;
	localparam int TAG_LEN_W  = 4;
	localparam int TAG_BITS_W = 64;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int TAG_IDX_W  = (MAX_TAG_BYTES > 1) ? $clog2(MAX_TAG_BYTES) : 1;

	localparam logic [16:0] ADLER_MOD = 17'd65521;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_BODY   = 2'd1;
	localparam logic [1:0] PH_HALT   = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_LEN  = 2'd1;
	localparam logic [1:0] ST_CHECKSUM = 2'd2;
	localparam logic [1:0] ST_BAD_TYPE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TAG_LENGTH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TAG_BYTES  = 2'd3;

	localparam logic [0:0] KIND_PAYLOAD = 1'b0;
	localparam logic [0:0] KIND_STATUS  = 1'b1;

	typedef struct packed {
		logic [CFG_LEN_W-1:0]  min_length;
		logic [CFG_LEN_W-1:0]  max_length;
		logic [TAG_LEN_W-1:0]  tag_length;
		logic [TAG_BITS_W-1:0] tag_bytes;
	} lpfc_cfg_t;

	typedef struct packed {
		logic [0:0]        kind;
		logic [7:0]        payload;
		logic [1:0]        status;
		logic [BODY_W-1:0] length;
	} lpfc_res_t;

	typedef struct packed {
		logic push;
		logic halted;
	} lpfc_stat_t;

endpackage

@@ rtl/core/lpfc_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfc_parser
// Frame state, header length check, running Adler-32 and end-of-frame status.
// ----------------------------------------------------------------------------
module lpfc_parser
	import lpfc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] byte_in,
	input  lpfc_cfg_t  cfg,
	output lpfc_res_t  res,
	output lpfc_stat_t stat
);

	localparam int LW = LENGTH_WIDTH;
	localparam int CW = LENGTH_WIDTH + 1;
	localparam logic [LW-1:0] FOUR = LW'(4);

	logic [1:0]    phase_q, phase_d;
	logic [31:0]   hdr_q, hdr_d;
	logic [LW-1:0] cnt_q, cnt_d;
	logic [LW-1:0] frame_q, frame_d;
	logic [15:0]   low_q, low_d, high_q, high_d;
	logic [31:0]   rs_q, rs_d;
	logic          tag_ok_q, tag_ok_d;

	logic [31:0]          raw;
	logic                 len_bad;
	logic [16:0]          low_sum, high_sum;
	logic [15:0]          low_new, high_new;
	logic [LW-1:0]        data_end;
	logic                 last;
	logic                 sum_ok;
	logic [TAG_LEN_W-1:0] tl;
	logic                 tag_short;
	logic                 in_tag;
	logic [7:0]           want;

	assign raw     = {hdr_q[23:0], byte_in};
	assign len_bad = (|raw[31:LW]) || (raw < 32'(cfg.min_length))
		|| (raw > 32'(cfg.max_length));

	assign low_sum  = {1'b0, low_q} + {9'b0, byte_in};
	assign low_new  = (low_sum >= ADLER_MOD) ? 16'(low_sum - ADLER_MOD) : low_sum[15:0];
	assign high_sum = {1'b0, high_q} + {1'b0, low_new};
	assign high_new = (high_sum >= ADLER_MOD) ? 16'(high_sum - ADLER_MOD) : high_sum[15:0];

	assign tl        = (cfg.tag_length > TAG_LEN_W'(MAX_TAG_BYTES)) ?
		TAG_LEN_W'(MAX_TAG_BYTES) : cfg.tag_length;
	assign data_end  = (frame_q >= FOUR) ? (frame_q - FOUR) : '0;
	assign last      = ({1'b0, cnt_q} + CW'(1)) >= {1'b0, frame_q};
	assign sum_ok    = {high_q, low_q} == {rs_q[23:0], byte_in};
	assign tag_short = {1'b0, frame_q} < (CW'(tl) + CW'(4));
	assign in_tag    = cnt_q < LW'(tl);
	assign want      = cfg.tag_bytes[{cnt_q[TAG_IDX_W-1:0], 3'b000} +: 8];

	always_comb begin
		phase_d  = phase_q;
		hdr_d    = hdr_q;
		cnt_d    = cnt_q;
		frame_d  = frame_q;
		low_d    = low_q;
		high_d   = high_q;
		rs_d     = rs_q;
		tag_ok_d = tag_ok_q;
		res      = '0;
		stat.push   = 1'b0;
		stat.halted = (phase_q == PH_HALT);
		if (step) begin
			case (phase_q)
				PH_HEADER: begin
					hdr_d = raw;
					if (cnt_q[1:0] == 2'd3) begin
						if (len_bad) begin
							phase_d     = PH_HALT;
							stat.push   = 1'b1;
							res.kind    = KIND_STATUS;
							res.status  = ST_BAD_LEN;
						end else if (raw == 32'd0) begin
							phase_d     = PH_HALT;
							stat.push   = 1'b1;
							res.kind    = KIND_STATUS;
							res.status  = ST_CHECKSUM;
						end else begin
							phase_d  = PH_BODY;
							frame_d  = raw[LW-1:0];
							cnt_d    = '0;
							low_d    = 16'd1;
							high_d   = 16'd0;
							rs_d     = 32'd0;
							tag_ok_d = 1'b1;
						end
					end else begin
						cnt_d = cnt_q + LW'(1);
					end
				end
				PH_BODY: begin
					cnt_d = cnt_q + LW'(1);
					if (cnt_q < data_end) begin
						low_d  = low_new;
						high_d = high_new;
						if (in_tag) begin
							if (want != byte_in) begin
								tag_ok_d = 1'b0;
							end
						end else begin
							stat.push   = 1'b1;
							res.kind    = KIND_PAYLOAD;
							res.payload = byte_in;
						end
					end else begin
						rs_d = {rs_q[23:0], byte_in};
					end
					if (last) begin
						stat.push  = 1'b1;
						res        = '0;
						res.kind   = KIND_STATUS;
						res.length = BODY_W'(frame_q);
						if ((frame_q < FOUR) || !sum_ok) begin
							phase_d    = PH_HALT;
							res.status = ST_CHECKSUM;
						end else if (tag_short || !tag_ok_q) begin
							phase_d    = PH_HALT;
							res.status = ST_BAD_TYPE;
						end else begin
							phase_d    = PH_HEADER;
							hdr_d      = 32'd0;
							cnt_d      = '0;
							res.status = ST_OK;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			hdr_q    <= 32'd0;
			cnt_q    <= '0;
			frame_q  <= '0;
			low_q    <= 16'd1;
			high_q   <= 16'd0;
			rs_q     <= 32'd0;
			tag_ok_q <= 1'b1;
		end else begin
			phase_q  <= phase_d;
			hdr_q    <= hdr_d;
			cnt_q    <= cnt_d;
			frame_q  <= frame_d;
			low_q    <= low_d;
			high_q   <= high_d;
			rs_q     <= rs_d;
			tag_ok_q <= tag_ok_d;
		end
	end

endmodule

@@ rtl/core/lpfc_outq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfc_outq
// Two-word result buffer; the second word holds a result pushed while the head is stalled.
// ----------------------------------------------------------------------------
module lpfc_outq
	import lpfc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  lpfc_res_t push_word,
	input  logic      out_stall,
	output logic      out_valid,
	output logic      full,
	output lpfc_res_t head
);

	logic [1:0] count_q;
	lpfc_res_t  ent0_q, ent1_q;
	logic       pop;

	assign out_valid = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign pop       = out_valid && !out_stall;
	assign head      = ent0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && (count_q == 2'd1)) begin
				ent0_q <= push_word;
			end else begin
				ent0_q <= ent1_q;
			end
			if (push && (count_q == 2'd2)) begin
				ent1_q <= push_word;
			end
		end else if (push) begin
			if (count_q == 2'd0) begin
				ent0_q <= push_word;
			end else begin
				ent1_q <= push_word;
			end
		end
	end

endmodule

@@ rtl/core/length_prefix_frame_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefix_frame_checker
// Datapath: input register, then the parser, then the two-word result buffer.
// Throughput: one byte per cycle when not stalled; the Adler-32 update and
// frame checks run in the single stage after the input register.
// Reset: asynchronous, active low; state registers reset, data words do not,
// and the checker waits for a frame header. An error halts it until reset.
// ----------------------------------------------------------------------------
module length_prefix_frame_checker
	import lpfc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            data_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [0:0]            item_kind,
	output logic [7:0]            payload_byte,
	output logic [1:0]            status_code,
	output logic [BODY_W-1:0]     body_length,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	lpfc_cfg_t  cfg_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       full;
	logic       step;
	lpfc_res_t  res;
	lpfc_res_t  head;
	lpfc_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_length <= CFG_LEN_W'(4);
			cfg_q.max_length <= CFG_LEN_W'(67108864);
			cfg_q.tag_length <= '0;
			cfg_q.tag_bytes  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_LENGTH: cfg_q.min_length <= cfg_data[CFG_LEN_W-1:0];
				CFG_MAX_LENGTH: cfg_q.max_length <= cfg_data[CFG_LEN_W-1:0];
				CFG_TAG_LENGTH: cfg_q.tag_length <= cfg_data[TAG_LEN_W-1:0];
				CFG_TAG_BYTES:  cfg_q.tag_bytes  <= cfg_data[TAG_BITS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_stall = valid_s1 && full;
	assign step     = valid_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= data_byte;
		end
	end

	lpfc_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.cfg     (cfg_q),
		.res     (res),
		.stat    (stat)
	);

	lpfc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (stat.push),
		.push_word (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.full      (full),
		.head      (head)
	);

	assign item_kind    = head.kind;
	assign payload_byte = head.payload;
	assign status_code  = head.status;
	assign body_length  = head.length;

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		stat.halted |-> !stat.push)
		else $error("result produced while halted");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty result buffer");

	a_ok_length: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (item_kind == KIND_STATUS) && (status_code == ST_OK))
		|-> (body_length >= BODY_W'(4)))
		else $error("good frame shorter than its checksum");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (item_kind == KIND_PAYLOAD))
		|-> ((status_code == ST_OK) && (body_length == '0)))
		else $error("payload word carries status fields");

endmodule
